/* design/htfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfc_pkg: shared types and constants for the sensor frame check and convert
// CRC-8 step function, channel codes and the fixed-point conversion constants.
// ----------------------------------------------------------------------------
package htfc_pkg;

  typedef enum logic {
    CH_TEMP = 1'b0,
    CH_HUM  = 1'b1
  } channel_t;

  localparam int unsigned NUM_LANES = 2;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [15:0] STATUS_MASK = 16'hFFFC;

  // Lane 0 is temperature, lane 1 is humidity. Offsets are negative and are
  // kept here as magnitudes.
  localparam logic [14:0] GAIN       [NUM_LANES] = '{15'd26813, 15'd19073};
  localparam logic [28:0] OFFSET_MAG [NUM_LANES] = '{29'd468500000, 29'd60000000};

  localparam logic [23:0] SCALE = 24'd10000000;

  // floor(a * RECIP_SCALE / 2^RECIP_SCALE_SHIFT) equals floor(a / SCALE)
  // for every a below 2^31.
  localparam logic [31:0] RECIP_SCALE       = 32'd3602879702;
  localparam int unsigned RECIP_SCALE_SHIFT = 55;

  // Same for division by ten of values below 2^24.
  localparam logic [24:0] RECIP_TEN       = 25'd26843546;
  localparam int unsigned RECIP_TEN_SHIFT = 28;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/humidity_temp_frame_check_convert_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_convert_unit
// Checks the CRC-8 of a temperature or humidity frame, keeps the last good
// sample of each channel and reports both as whole units and millionths.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_valid/in_ready   | channel, byte_high, byte_low, check_byte
//  out_    | output    | out_valid/out_ready | crc_ok, temp/hum whole and millionths
//
// One item per cycle sustained while out_ready lets results leave; each item
// passes through the six register stages of the conversion pipeline.
// Reset clears the stored samples to zero and empties the pipeline.
// Each stage moves on whenever the stage after it is empty or moving, so bubbles
// close up and items are still taken while a result waits, until all are full.
// ----------------------------------------------------------------------------
module humidity_temp_frame_check_convert_unit
  import htfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_channel,
  input  logic [7:0]         in_byte_high,
  input  logic [7:0]         in_byte_low,
  input  logic [7:0]         in_check_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_crc_ok,
  output logic signed [8:0]  out_temp_whole,
  output logic signed [20:0] out_temp_millionths,
  output logic signed [7:0]  out_hum_whole,
  output logic signed [20:0] out_hum_millionths
);

  localparam int unsigned NSTG = 6;

  // Stage valid bits; the last one is the output register.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  // Stage 1: input register.
  logic       ch_r;
  logic [7:0] bh_r, bl_r, ck_r;

  // Stored samples.
  logic [15:0] samp_r   [NUM_LANES];
  logic [15:0] samp_nxt [NUM_LANES];

  // Stage 2: products.
  logic        ok2_r;
  logic [30:0] prod_r   [NUM_LANES];
  logic [30:0] prod_nxt [NUM_LANES];
  logic        ok_nxt;
  logic [7:0]  crc;
  logic [15:0] clean;

  // Stage 3: sign and magnitude.
  logic        ok3_r;
  logic        neg3_r   [NUM_LANES];
  logic [30:0] mag3_r   [NUM_LANES];
  logic        neg_nxt  [NUM_LANES];
  logic [30:0] mag_nxt  [NUM_LANES];
  logic signed [31:0] v [NUM_LANES];

  // Stage 4: quotient.
  logic        ok4_r;
  logic        neg4_r   [NUM_LANES];
  logic [30:0] mag4_r   [NUM_LANES];
  logic [7:0]  quo4_r   [NUM_LANES];
  logic [7:0]  quo_nxt  [NUM_LANES];
  logic [62:0] qprod    [NUM_LANES];

  // Stage 5: remainder.
  logic        ok5_r;
  logic        neg5_r   [NUM_LANES];
  logic [7:0]  quo5_r   [NUM_LANES];
  logic [23:0] rem5_r   [NUM_LANES];
  logic [23:0] rem_nxt  [NUM_LANES];
  logic [31:0] qs       [NUM_LANES];

  // Output stage.
  logic        mprod_ok;
  logic [48:0] mprod    [NUM_LANES];
  logic [8:0]  whole_nxt [NUM_LANES];
  logic [20:0] mil_nxt   [NUM_LANES];
  logic        crc_ok_r;
  logic [8:0]  tw_r;
  logic [20:0] tm_r;
  logic [7:0]  hw_r;
  logic [20:0] hm_r;

  // Ready chain from the output back to the input.
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1 logic: CRC check, sample update and the gain products.
  always_comb begin
    crc    = crc8_byte(crc8_byte(8'h00, bh_r), bl_r);
    ok_nxt = (crc == ck_r);
    clean  = {bh_r, bl_r} & STATUS_MASK;
    samp_nxt[0] = (ok_nxt && (ch_r == CH_TEMP)) ? clean : samp_r[0];
    samp_nxt[1] = (ok_nxt && (ch_r == CH_HUM))  ? clean : samp_r[1];
    for (int i = 0; i < NUM_LANES; i++) begin
      prod_nxt[i] = 31'(samp_nxt[i]) * 31'(GAIN[i]);
    end
  end

  // The item updates the stored samples as it leaves stage 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r[0] <= '0;
      samp_r[1] <= '0;
    end else if (vld_r[0] && en[1]) begin
      samp_r[0] <= samp_nxt[0];
      samp_r[1] <= samp_nxt[1];
    end
  end

  // Stage 2 logic: apply the offset and split off the sign.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      v[i]       = $signed({1'b0, prod_r[i]}) - $signed({3'b000, OFFSET_MAG[i]});
      neg_nxt[i] = v[i][31];
      mag_nxt[i] = neg_nxt[i] ? 31'(-v[i]) : 31'(v[i]);
    end
  end

  // Stage 3 logic: quotient by reciprocal multiplication, exact in range.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      qprod[i]   = 63'(mag3_r[i]) * 63'(RECIP_SCALE);
      quo_nxt[i] = qprod[i][RECIP_SCALE_SHIFT +: 8];
    end
  end

  // Stage 4 logic: remainder of the magnitude; the sign is restored in stage 5.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      qs[i]      = 32'(quo4_r[i]) * 32'(SCALE);
      rem_nxt[i] = 24'(32'(mag4_r[i]) - qs[i]);
    end
  end

  // Stage 5 logic: millionths from the remainder, then restore the sign.
  always_comb begin
    mprod_ok = ok5_r;
    for (int i = 0; i < NUM_LANES; i++) begin
      mprod[i]     = 49'(rem5_r[i]) * 49'(RECIP_TEN);
      whole_nxt[i] = neg5_r[i] ? 9'(-{1'b0, quo5_r[i]}) : {1'b0, quo5_r[i]};
      mil_nxt[i]   = neg5_r[i] ? 21'(-{1'b0, mprod[i][RECIP_TEN_SHIFT +: 20]})
                               : {1'b0, mprod[i][RECIP_TEN_SHIFT +: 20]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ch_r <= in_channel;
      bh_r <= in_byte_high;
      bl_r <= in_byte_low;
      ck_r <= in_check_byte;
    end
    if (en[1]) begin
      ok2_r <= ok_nxt;
      for (int i = 0; i < NUM_LANES; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (en[2]) begin
      ok3_r <= ok2_r;
      for (int i = 0; i < NUM_LANES; i++) begin
        neg3_r[i] <= neg_nxt[i];
        mag3_r[i] <= mag_nxt[i];
      end
    end
    if (en[3]) begin
      ok4_r <= ok3_r;
      for (int i = 0; i < NUM_LANES; i++) begin
        neg4_r[i] <= neg3_r[i];
        mag4_r[i] <= mag3_r[i];
        quo4_r[i] <= quo_nxt[i];
      end
    end
    if (en[4]) begin
      ok5_r <= ok4_r;
      for (int i = 0; i < NUM_LANES; i++) begin
        neg5_r[i] <= neg4_r[i];
        quo5_r[i] <= quo4_r[i];
        rem5_r[i] <= rem_nxt[i];
      end
    end
    if (en[5]) begin
      crc_ok_r <= mprod_ok;
      tw_r     <= whole_nxt[0];
      tm_r     <= mil_nxt[0];
      hw_r     <= whole_nxt[1][7:0];
      hm_r     <= mil_nxt[1];
    end
  end

  assign out_valid           = vld_r[NSTG-1];
  assign out_crc_ok          = crc_ok_r;
  assign out_temp_whole      = $signed(tw_r);
  assign out_temp_millionths = $signed(tm_r);
  assign out_hum_whole       = $signed(hw_r);
  assign out_hum_millionths  = $signed(hm_r);

endmodule

/* design/htfc_port_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfc_port_checker: port-level checks for the frame check and convert unit
// Watches the handshakes and the shape of the converted results.
// ----------------------------------------------------------------------------
module htfc_port_checker
  import htfc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_crc_ok,
  input logic signed [8:0]  out_temp_whole,
  input logic signed [20:0] out_temp_millionths,
  input logic signed [7:0]  out_hum_whole,
  input logic signed [20:0] out_hum_millionths
);

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_crc_ok)
      && $stable(out_temp_whole) && $stable(out_temp_millionths)
      && $stable(out_hum_whole) && $stable(out_hum_millionths))
    else $error("stalled result changed");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With no result waiting, every stage can move, so an item is taken.
  assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // Whole and fractional parts agree in sign.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_temp_whole < 0 && out_temp_millionths > 0)
      && !(out_temp_whole > 0 && out_temp_millionths < 0)
      && !(out_hum_whole < 0 && out_hum_millionths > 0)
      && !(out_hum_whole > 0 && out_hum_millionths < 0))
    else $error("whole and millionths differ in sign");

  // Fractional parts stay below one unit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_millionths <= 21'sd999999
      && out_temp_millionths >= -21'sd999999
      && out_hum_millionths <= 21'sd999999
      && out_hum_millionths >= -21'sd999999)
    else $error("millionths out of range");

endmodule

bind humidity_temp_frame_check_convert_unit htfc_port_checker u_htfc_port_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_crc_ok          (out_crc_ok),
  .out_temp_whole      (out_temp_whole),
  .out_temp_millionths (out_temp_millionths),
  .out_hum_whole       (out_hum_whole),
  .out_hum_millionths  (out_hum_millionths)
);
